// ===== rtl/b64sd_pkg.sv =====
package b64sd_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BADPAD  = 2'd2;
    localparam logic [1:0] ST_LENGTH  = 2'd3;

    localparam int GROUP_BYTES = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] val;
    } sextet_t;

    // One completed group: up to three bytes, or a single error beat.
    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] data;
        logic [1:0]                  cnt;
        logic                        last;
        logic [1:0]                  status;
    } group_rec_t;

    function automatic sextet_t map_char(input logic [7:0] c);
        sextet_t m;
        m = '{bad: 1'b0, pad: 1'b0, val: 6'd0};
        case (c) inside
            [8'h41:8'h5A]: m.val = 6'(c - 8'h41);
            [8'h61:8'h7A]: m.val = 6'(c - 8'h47);
            [8'h30:8'h39]: m.val = 6'(c + 8'h04);
            8'h2B:         m.val = 6'd62;
            8'h2F:         m.val = 6'd63;
            8'h3D:         m.pad = 1'b1;
            default:       m.bad = 1'b1;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/b64sd_in_if.sv =====
interface b64sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ===== rtl/b64sd_out_if.sv =====
interface b64sd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] out_status;

    modport source (output valid, output out_byte, output out_last, output out_status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_status,
                    output ready);
endinterface

// ===== rtl/base64_stream_decoder_unit.sv =====
// Base64 decoder: takes one character per cycle on chars and returns decoded bytes on
// bytes, one per cycle. Each character is mapped and folded into the group state in the
// cycle it is accepted; a completed group (or a short final group) is written as one
// record into a two-entry queue, which a serializer drains one byte per cycle, so three
// bytes per four characters flow with no stall at steady state. A group's bytes are read
// from its registered queue record once earlier records have drained. chars.ready drops only
// while both queue entries are occupied, which the downstream side sets by holding
// bytes.ready low. Faulty groups give one beat with a zero byte and a nonzero status.
module base64_stream_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    b64sd_in_if.sink            chars,
    b64sd_out_if.source         bytes
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        pad_reg, pad_next;
    logic [1:0]  err_reg, err_next;
    logic [1:0]  err_cur;
    logic [5:0]  val;

    b64sd_pkg::sextet_t     m;
    b64sd_pkg::group_rec_t  rec_new;
    b64sd_pkg::group_rec_t  head;
    b64sd_pkg::group_rec_t  rec_mem [b64sd_pkg::QUEUE_DEPTH];

    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  sub_reg;
    logic        in_fire, out_fire, push, pop, beat_last;

    assign in_fire  = chars.valid && chars.ready;
    assign out_fire = bytes.valid && bytes.ready;

    always_comb
    begin
        m   = b64sd_pkg::map_char(chars.in_char);
        val = (m.bad || m.pad) ? 6'd0 : m.val;

        // first fault of the group wins
        err_cur = err_reg;
        if (err_reg == b64sd_pkg::ST_OK)
        begin
            if (m.bad)
                err_cur = b64sd_pkg::ST_INVALID;
            else if (m.pad && pos_reg < 2'd2)
                err_cur = b64sd_pkg::ST_BADPAD;
            else if (!m.pad && pad_reg)
                err_cur = b64sd_pkg::ST_BADPAD;
        end

        pos_next = pos_reg;
        acc_next = acc_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        push     = 1'b0;
        rec_new  = '0;

        if (in_fire)
        begin
            if (pos_reg != 2'd3)
            begin
                acc_next = {acc_reg[11:0], val};
                if (m.pad && pos_reg == 2'd2)
                    pad_next = 1'b1;
                pos_next = pos_reg + 2'd1;
                err_next = err_cur;
                if (chars.in_last)
                begin
                    push           = 1'b1;
                    rec_new.cnt    = 2'd1;
                    rec_new.last   = 1'b1;
                    rec_new.status = (err_cur != b64sd_pkg::ST_OK) ? err_cur
                                                                   : b64sd_pkg::ST_LENGTH;
                    pos_next = 2'd0;
                    acc_next = '0;
                    pad_next = 1'b0;
                    err_next = b64sd_pkg::ST_OK;
                end
            end
            else
            begin
                push         = 1'b1;
                rec_new.last = chars.in_last;
                if (err_cur != b64sd_pkg::ST_OK)
                begin
                    rec_new.cnt    = 2'd1;
                    rec_new.status = err_cur;
                end
                else
                begin
                    rec_new.data[0] = acc_reg[17:10];
                    rec_new.data[1] = acc_reg[9:2];
                    rec_new.data[2] = {acc_reg[1:0], val};
                    rec_new.cnt     = 2'd3 - {1'b0, pad_reg} - {1'b0, m.pad};
                    rec_new.status  = b64sd_pkg::ST_OK;
                end
                pos_next = 2'd0;
                acc_next = '0;
                pad_next = 1'b0;
                err_next = b64sd_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            acc_reg <= '0;
            pad_reg <= 1'b0;
            err_reg <= b64sd_pkg::ST_OK;
        end
        else
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
        end
    end

    // Group record queue
    always_ff @(posedge clk)
    begin
        if (push)
            rec_mem[wr_ptr_reg] <= rec_new;
    end

    assign head      = rec_mem[rd_ptr_reg];
    assign beat_last = (sub_reg == head.cnt - 2'd1);
    assign pop       = out_fire && beat_last;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                sub_reg    <= 2'd0;
            end
            else if (out_fire)
                sub_reg <= sub_reg + 2'd1;
        end
    end

    assign chars.ready      = (count_reg != 2'(b64sd_pkg::QUEUE_DEPTH));
    assign bytes.valid      = (count_reg != 2'd0);
    assign bytes.out_byte   = head.data[sub_reg];
    assign bytes.out_last   = head.last && beat_last;
    assign bytes.out_status = head.status;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(b64sd_pkg::QUEUE_DEPTH))
        else $error("record queue overflow");

    a_sub_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        bytes.valid |-> (sub_reg < head.cnt))
        else $error("byte index past end of group");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes.valid && bytes.out_status != b64sd_pkg::ST_OK)
            |-> (bytes.out_byte == 8'd0 && head.cnt == 2'd1))
        else $error("error result carries data");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && chars.in_last)
            |=> (pos_reg == 2'd0 && !pad_reg && err_reg == b64sd_pkg::ST_OK))
        else $error("group state not cleared after final character");

endmodule
